### rtl/core/command_line_tokenizer_assert.svh
// Assertion macros for the command line tokenizer checker.
// Needs clk and arst_n in the scope of use.
`ifndef COMMAND_LINE_TOKENIZER_ASSERT_SVH
`define COMMAND_LINE_TOKENIZER_ASSERT_SVH
// implication checked on every clock edge outside reset
`define CLT_ASSERT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("command_line_tokenizer assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define CLT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("command_line_tokenizer assertion failed");
`endif

### rtl/core/clt_pkg.sv
// Shared types and constants of the command line tokenizer.
// No dependencies.
package clt_pkg;
	localparam int NUMBER_WIDTH = 64;
	localparam int MAX_RESULTS  = 6;

	localparam logic [2:0] K_CMD  = 3'd0;
	localparam logic [2:0] K_BYTE = 3'd1;
	localparam logic [2:0] K_END  = 3'd2;
	localparam logic [2:0] K_INT  = 3'd3;
	localparam logic [2:0] K_NULL = 3'd4;
	localparam logic [2:0] K_LINE = 3'd5;

	typedef struct packed {
		logic [7:0] line_byte;
		logic       end_of_line;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         record_kind;
		logic signed [63:0] record_value;
		logic               argument_index;
		logic               last_of_run;
	} out_item_t;

	// command names, first byte in the low bits, zero padded
	localparam logic [39:0] CMD_LOWER [11] = '{
		40'h0000746573, 40'h0000746567, 40'h00006c6564, 40'h0000706f70,
		40'h00676e6970, 40'h0068737570, 40'h007465737a,
		40'h007361687a, 40'h006c65647a, 40'h6575716e65, 40'h6575716564};
	localparam logic [39:0] CMD_UPPER [11] = '{
		40'h0000544553, 40'h0000544547, 40'h00004c4544, 40'h0000504f50,
		40'h00474e4950, 40'h0048535550, 40'h005445535a,
		40'h005341485a, 40'h004c45445a, 40'h4555514e45, 40'h4555514544};
	localparam logic [2:0] CMD_LEN [11] = '{3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4,
		3'd4, 3'd4, 3'd4, 3'd5, 3'd5};

	function automatic logic [3:0] lookup_word(logic [39:0] buf_w, logic [2:0] len);
		logic [3:0] code;
		code = 4'd0;
		for (int k = 10; k >= 0; k--) begin
			if (len == CMD_LEN[k] && (buf_w == CMD_LOWER[k] || buf_w == CMD_UPPER[k]))
				code = 4'(k + 1);
		end
		return code;
	endfunction

	function automatic logic [1:0] num_args(logic [3:0] code);
		logic [1:0] n;
		unique case (code)
			4'd1: n = 2'd2;
			4'd2, 4'd3, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10: n = 2'd1;
			default: n = 2'd0;
		endcase
		return n;
	endfunction
endpackage

### rtl/core/command_line_tokenizer.sv
// Command line tokenizer top level.
// Depends on clt_pkg.
//
// channel | dir | payload
// in      | in  | clt_pkg::in_item_t  (line_byte, end_of_line)
// out     | out | clt_pkg::out_item_t (one record per item)
//
// At most one input item is taken per cycle; its 0 to 6 records are computed in
// the accept cycle and drained from a result buffer one per cycle while out_ready
// is high. in_ready stays high while the last buffered record leaves. Reset
// returns the parser to the leading whitespace phase and empties the buffer.
// Stalls on out hold the buffer.
module command_line_tokenizer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  clt_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output clt_pkg::out_item_t  out_data
);
	localparam int NW = clt_pkg::NUMBER_WIDTH;

	typedef enum logic [2:0] {
		PH_LEAD, PH_WORD, PH_GAP, PH_PLAIN, PH_QUOTED, PH_NUMBER, PH_DONE
	} phase_t;

	typedef struct packed {
		phase_t        phase;
		logic [39:0]   wbuf;
		logic [2:0]    wlen;
		logic [3:0]    cmd;
		logic [1:0]    args;
		logic [NW-1:0] acc;
		logic          neg;
		logic          bs;
		logic          minus;
	} state_t;

	typedef struct {
		state_t             st;
		clt_pkg::out_item_t recs [clt_pkg::MAX_RESULTS];
		logic [2:0]         cnt;
	} work_t;

	localparam state_t ST_RESET = '{PH_LEAD, 40'd0, 3'd0, 4'd0, 2'd0, '0, 1'b0, 1'b0, 1'b0};

	function automatic work_t emit(work_t w, logic [2:0] k, logic [63:0] v, logic idx);
		work_t r;
		r = w;
		if (r.cnt < 3'(clt_pkg::MAX_RESULTS)) begin
			r.recs[r.cnt] = '{k, v, idx, 1'b0};
			r.cnt = r.cnt + 3'd1;
		end
		return r;
	endfunction

	function automatic work_t end_word(work_t w);
		work_t r;
		r = w;
		r.st.cmd = clt_pkg::lookup_word(r.st.wbuf, r.st.wlen);
		r = emit(r, clt_pkg::K_CMD, 64'(r.st.cmd), 1'b0);
		r.st.args = 2'd0;
		r.st.phase = (clt_pkg::num_args(r.st.cmd) != 2'd0) ? PH_GAP : PH_DONE;
		return r;
	endfunction

	function automatic work_t arg_finished(work_t w);
		work_t r;
		r = w;
		r.st.args = r.st.args + 2'd1;
		r.st.phase = (r.st.args < clt_pkg::num_args(r.st.cmd)) ? PH_GAP : PH_DONE;
		return r;
	endfunction

	function automatic work_t fill_nulls(work_t w);
		work_t r;
		r = w;
		for (int i = 0; i < 2; i++) begin
			if (r.st.args < clt_pkg::num_args(r.st.cmd)) begin
				r = emit(r, clt_pkg::K_NULL, 64'd0, r.st.args[0]);
				r.st.args = r.st.args + 2'd1;
			end
		end
		r.st.phase = PH_DONE;
		return r;
	endfunction

	function automatic work_t feed(work_t w, logic [7:0] b);
		work_t r;
		logic again;
		logic done;
		logic is_digit;
		logic alpha;
		logic is_ws;
		logic [7:0] mapped;
		logic [NW-1:0] v;
		r = w;
		again = 1'b1;
		done = 1'b0;
		mapped = 8'd0;
		v = '0;
		is_digit = (b >= "0") && (b <= "9");
		alpha = ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
		is_ws = (b == " ") || (b == 8'd9);
		for (int i = 0; i < 4; i++) begin
			if (again) begin
				again = 1'b0;
				unique case (r.st.phase)
					PH_LEAD: begin
						if (is_ws) begin
						end else if (b == 8'd0) begin
							r = end_word(r);
						end else begin
							r.st.wbuf = 40'(b);
							r.st.wlen = 3'd1;
							r.st.phase = PH_WORD;
						end
					end
					PH_WORD: begin
						if (b == " ") begin
							r = end_word(r);
						end else if (b == 8'd0) begin
							r = end_word(r);
							again = 1'b1;
						end else if (r.st.wlen < 3'd5) begin
							r.st.wbuf = r.st.wbuf | (40'(b) << {r.st.wlen, 3'b000});
							r.st.wlen = r.st.wlen + 3'd1;
						end else begin
							r.st.wlen = 3'd6;
						end
					end
					PH_GAP: begin
						if (r.st.minus) begin
							r.st.minus = 1'b0;
							if (is_digit) begin
								r.st.acc = NW'(b - "0");
								r.st.neg = 1'b1;
								r.st.phase = PH_NUMBER;
							end else begin
								r = fill_nulls(r);
							end
						end else if (is_ws) begin
						end else if (alpha) begin
							r = emit(r, clt_pkg::K_BYTE, 64'(b), r.st.args[0]);
							r.st.phase = PH_PLAIN;
						end else if (b == 8'h22) begin
							r.st.phase = PH_QUOTED;
						end else if (is_digit) begin
							r.st.acc = NW'(b - "0");
							r.st.neg = 1'b0;
							r.st.phase = PH_NUMBER;
						end else if (b == "-") begin
							r.st.minus = 1'b1;
						end else begin
							r = fill_nulls(r);
						end
					end
					PH_PLAIN: begin
						if (b == " " || b == 8'd0) begin
							r = emit(r, clt_pkg::K_END, 64'd0, r.st.args[0]);
							r = arg_finished(r);
							again = (b == 8'd0);
						end else begin
							r = emit(r, clt_pkg::K_BYTE, 64'(b), r.st.args[0]);
						end
					end
					PH_QUOTED: begin
						done = 1'b0;
						if (r.st.bs) begin
							r.st.bs = 1'b0;
							unique case (b)
								"n":     mapped = 8'd10;
								"r":     mapped = 8'd13;
								"t":     mapped = 8'd9;
								8'h22:   mapped = 8'h22;
								default: mapped = 8'd0;
							endcase
							if (mapped != 8'd0) begin
								r = emit(r, clt_pkg::K_BYTE, 64'(mapped), r.st.args[0]);
								done = 1'b1;
							end else begin
								r = emit(r, clt_pkg::K_BYTE, 64'h5c, r.st.args[0]);
							end
						end
						if (!done) begin
							if (b == 8'h22 || b == 8'd0) begin
								r = emit(r, clt_pkg::K_END, 64'd0, r.st.args[0]);
								r = arg_finished(r);
								again = (b == 8'd0);
							end else if (b == 8'h5c) begin
								r.st.bs = 1'b1;
							end else begin
								r = emit(r, clt_pkg::K_BYTE, 64'(b), r.st.args[0]);
							end
						end
					end
					PH_NUMBER: begin
						if (is_digit) begin
							r.st.acc = (r.st.acc << 3) + (r.st.acc << 1) + NW'(b - "0");
						end else begin
							v = r.st.neg ? (NW'(0) - r.st.acc) : r.st.acc;
							r = emit(r, clt_pkg::K_INT, 64'(signed'(v)), r.st.args[0]);
							r = arg_finished(r);
							again = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end
		return r;
	endfunction

	state_t             st_q;
	clt_pkg::out_item_t recs_q [clt_pkg::MAX_RESULTS];
	logic [2:0]         cnt_q;
	logic [2:0]         rd_q;
	work_t              w;
	logic               in_fire;
	logic               out_fire;

	always_comb begin
		w.st = st_q;
		w.cnt = 3'd0;
		for (int i = 0; i < clt_pkg::MAX_RESULTS; i++)
			w.recs[i] = '0;
		w = feed(w, in_data.line_byte);
		if (in_data.end_of_line) begin
			w = feed(w, 8'd0);
			w = emit(w, clt_pkg::K_LINE, 64'd0, 1'b0);
			w.st = ST_RESET;
		end
		if (w.cnt != 3'd0)
			w.recs[w.cnt - 3'd1].last_of_run = 1'b1;
	end

	assign out_valid = rd_q < cnt_q;
	assign out_data  = recs_q[rd_q];
	assign in_ready  = !out_valid || (out_ready && (rd_q + 3'd1 == cnt_q));
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_RESET;
			cnt_q <= 3'd0;
			rd_q  <= 3'd0;
		end else if (in_fire) begin
			st_q  <= w.st;
			cnt_q <= w.cnt;
			rd_q  <= 3'd0;
		end else if (out_fire) begin
			rd_q <= rd_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire)
			recs_q <= w.recs;
	end
endmodule

### rtl/core/command_line_tokenizer_checker.sv
// Port level checker for the command line tokenizer, bound to the top level.
// Depends on clt_pkg and command_line_tokenizer_assert.svh.
`include "command_line_tokenizer_assert.svh"
module command_line_tokenizer_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input clt_pkg::out_item_t out_data
);
	logic line_rec;
	logic zero_rec;

	assign line_rec = out_valid && out_data.record_kind == clt_pkg::K_LINE;
	assign zero_rec = out_valid && (out_data.record_kind == clt_pkg::K_END
		|| out_data.record_kind == clt_pkg::K_NULL || out_data.record_kind == clt_pkg::K_LINE);

	`CLT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
	`CLT_ASSERT(a_line_last, line_rec, out_data.last_of_run)
	`CLT_ASSERT(a_zero_value, zero_rec, out_data.record_value == 64'sd0)
	`CLT_ASSERT(a_ready_busy, out_valid && !out_ready, !in_ready)
endmodule

bind command_line_tokenizer command_line_tokenizer_checker u_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data));

### dv/tb_command_line_tokenizer.sv
// Self-checking testbench for command_line_tokenizer: random and directed command lines,
// predicted record by record and compared in order. Depends on clt_pkg and the tokenizer RTL.
`default_nettype none
module tb_command_line_tokenizer;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [2:0] {P_LEAD, P_WORD, P_GAP, P_PLAIN, P_QUOTED, P_NUMBER, P_DONE} tb_phase_t;
	typedef logic [7:0] byte_q_t[$];

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	clt_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	clt_pkg::out_item_t out_data;

	command_line_tokenizer uut (.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.out_valid, .out_ready, .out_data);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	clt_pkg::in_item_t pending_bytes[$];
	clt_pkg::out_item_t expected_recs[$];
	clt_pkg::out_item_t step_recs[$];
	int errors = 0, lines_sent = 0, bytes_taken = 0, recs_checked = 0;
	int send_idle_pct = 0, recv_stall_pct = 0, hold_cycles = 0, quiet_cycles = 0;

	string cmd_names[11] = '{"set", "get", "del", "pop", "ping", "push",
		"zset", "zhas", "zdel", "enque", "deque"};

	// tokenizer state mirror
	tb_phase_t phase;
	logic [39:0] word_buf;
	int word_len;
	int cmd_code;
	int args_done;
	logic [63:0] num_acc;
	logic num_neg, pend_bs, pend_minus;

	function automatic int args_of(int code);
		case (code)
			1: return 2;
			2, 3, 6, 7, 8, 9, 10: return 1;
			default: return 0;
		endcase
	endfunction

	function automatic bit is_digit(logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic bit is_alpha(logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	task automatic clear_state();
		phase = P_LEAD;
		word_buf = '0;
		word_len = 0;
		cmd_code = 0;
		args_done = 0;
		num_acc = '0;
		num_neg = 1'b0;
		pend_bs = 1'b0;
		pend_minus = 1'b0;
	endtask

	task automatic add_rec(logic [2:0] kind, logic [63:0] value, int idx);
		clt_pkg::out_item_t r;
		r.record_kind = kind;
		r.record_value = value;
		r.argument_index = idx[0];
		r.last_of_run = 1'b0;
		if (step_recs.size() < clt_pkg::MAX_RESULTS)
			step_recs.push_back(r);
	endtask

	function automatic int match_word();
		bit lo, up;
		logic [7:0] b, c;
		for (int k = 0; k < 11; k++) begin
			if (cmd_names[k].len() != word_len)
				continue;
			lo = 1;
			up = 1;
			for (int i = 0; i < word_len; i++) begin
				b = word_buf[8*i +: 8];
				c = cmd_names[k][i];
				if (b != c) lo = 0;
				if (b != c - 8'd32) up = 0;
			end
			if (lo || up)
				return k + 1;
		end
		return 0;
	endfunction

	task automatic close_word();
		cmd_code = match_word();
		add_rec(clt_pkg::K_CMD, 64'(cmd_code), 0);
		args_done = 0;
		phase = args_of(cmd_code) > 0 ? P_GAP : P_DONE;
	endtask

	task automatic next_arg();
		args_done = (args_done + 1) & 3;
		phase = args_done < args_of(cmd_code) ? P_GAP : P_DONE;
	endtask

	task automatic nulls_to_end();
		while (args_done < args_of(cmd_code)) begin
			add_rec(clt_pkg::K_NULL, '0, args_done);
			args_done++;
		end
		phase = P_DONE;
	endtask

	task automatic parse_byte(logic [7:0] b);
		bit again;
		logic [7:0] mapped;
		again = 1;
		while (again) begin
			again = 0;
			case (phase)
				P_LEAD: begin
					if (b == " " || b == 8'h09) ;
					else if (b == 8'h00) close_word();
					else begin
						word_buf = {32'h0, b};
						word_len = 1;
						phase = P_WORD;
					end
				end
				P_WORD: begin
					if (b == " ") close_word();
					else if (b == 8'h00) begin
						close_word();
						again = 1;
					end else if (word_len < 5) begin
						word_buf[8*word_len +: 8] = b;
						word_len++;
					end else word_len = 6;
				end
				P_GAP: begin
					if (pend_minus) begin
						pend_minus = 0;
						if (is_digit(b)) begin
							num_acc = 64'(b - "0");
							num_neg = 1;
							phase = P_NUMBER;
						end else nulls_to_end();
					end else if (b == " " || b == 8'h09) ;
					else if (is_alpha(b)) begin
						add_rec(clt_pkg::K_BYTE, 64'(b), args_done);
						phase = P_PLAIN;
					end else if (b == "\"") phase = P_QUOTED;
					else if (is_digit(b)) begin
						num_acc = 64'(b - "0");
						num_neg = 0;
						phase = P_NUMBER;
					end else if (b == "-") pend_minus = 1;
					else nulls_to_end();
				end
				P_PLAIN: begin
					if (b == " " || b == 8'h00) begin
						add_rec(clt_pkg::K_END, '0, args_done);
						next_arg();
						again = (b == 8'h00);
					end else add_rec(clt_pkg::K_BYTE, 64'(b), args_done);
				end
				P_QUOTED: begin
					mapped = 8'h00;
					if (pend_bs) begin
						pend_bs = 0;
						case (b)
							"n": mapped = 8'd10;
							"r": mapped = 8'd13;
							"t": mapped = 8'd9;
							"\"": mapped = "\"";
							default: mapped = 8'h00;
						endcase
						if (mapped != 8'h00) add_rec(clt_pkg::K_BYTE, 64'(mapped), args_done);
						else add_rec(clt_pkg::K_BYTE, 64'("\\"), args_done);
					end
					if (mapped == 8'h00) begin
						if (b == "\"" || b == 8'h00) begin
							add_rec(clt_pkg::K_END, '0, args_done);
							next_arg();
							again = (b == 8'h00);
						end else if (b == "\\") pend_bs = 1;
						else add_rec(clt_pkg::K_BYTE, 64'(b), args_done);
					end
				end
				P_NUMBER: begin
					if (is_digit(b)) num_acc = num_acc * 64'd10 + 64'(b - "0");
					else begin
						add_rec(clt_pkg::K_INT, num_neg ? -num_acc : num_acc, args_done);
						next_arg();
						again = 1;
					end
				end
				default: ;
			endcase
		end
	endtask

	task automatic predict_item(clt_pkg::in_item_t it);
		step_recs.delete();
		parse_byte(it.line_byte);
		if (it.end_of_line) begin
			parse_byte(8'h00);
			add_rec(clt_pkg::K_LINE, '0, 0);
			clear_state();
		end
		if (step_recs.size() > 0)
			step_recs[step_recs.size()-1].last_of_run = 1'b1;
		foreach (step_recs[i])
			expected_recs.push_back(step_recs[i]);
	endtask

	task automatic report_mismatch(string what, clt_pkg::out_item_t got,
		clt_pkg::out_item_t want);
		errors++;
		$display("mismatch %0t: %s got kind=%0d val=%0d idx=%0d last=%0b",
			$realtime, what, got.record_kind, got.record_value, got.argument_index,
			got.last_of_run, " want kind=%0d val=%0d idx=%0d last=%0b",
			want.record_kind, want.record_value, want.argument_index, want.last_of_run);
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n && (!in_valid || in_ready)) begin
			if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				in_data <= pending_bytes.pop_front();
				in_valid <= 1'b1;
			end else in_valid <= 1'b0;
		end
	end

	// receiver
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else out_ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	// monitor, predictor and watchdog
	always @(posedge clk) begin
		clt_pkg::out_item_t want;
		if (in_valid && in_ready) begin
			predict_item(in_data);
			bytes_taken++;
		end
		if (out_valid && out_ready) begin
			if (expected_recs.size() == 0) report_mismatch("unexpected", out_data, '0);
			else begin
				want = expected_recs.pop_front();
				recs_checked++;
				if (out_data !== want) report_mismatch("field", out_data, want);
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 5000) begin
			$display("timeout waiting on handshake");
			$display("FAILURE");
			$finish;
		end
	end

	task automatic queue_line(byte_q_t bq);
		clt_pkg::in_item_t it;
		foreach (bq[i]) begin
			it.line_byte = bq[i];
			it.end_of_line = (i == bq.size() - 1);
			pending_bytes.push_back(it);
		end
		lines_sent++;
	endtask

	function automatic byte_q_t text(string s);
		byte_q_t q;
		for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
		return q;
	endfunction

	function automatic logic [7:0] gap_byte();
		return $urandom_range(2) == 0 ? 8'h09 : " ";
	endfunction

	function automatic byte_q_t random_line();
		byte_q_t q;
		string w;
		int n, k;
		if ($urandom_range(9) == 0) begin
			n = $urandom_range(6, 1);
			repeat (n) q.push_back(8'($urandom_range(255)));
			return q;
		end
		repeat ($urandom_range(2)) q.push_back(gap_byte());
		k = $urandom_range(11);
		if (k < 11) begin
			w = cmd_names[k];
			if ($urandom_range(1)) w = w.toupper();
			if ($urandom_range(15) == 0) w[0] = w[0] ^ 8'h20;
		end else begin
			w = "";
			repeat ($urandom_range(7, 1)) w = {w, string'(8'($urandom_range(122, 97)))};
		end
		for (int i = 0; i < w.len(); i++) q.push_back(w[i]);
		n = $urandom_range(3);
		for (int a = 0; a < n; a++) begin
			if ($urandom_range(4) != 0 || a == 0) begin
				q.push_back(" ");
				repeat ($urandom_range(1)) q.push_back(gap_byte());
			end
			case ($urandom_range(9))
				0, 1, 2: begin
					q.push_back(8'($urandom_range(90, 65)) | (8'($urandom_range(1)) << 5));
					repeat ($urandom_range(4)) q.push_back(8'($urandom_range(126, 33)));
				end
				3, 4, 5: begin
					q.push_back("\"");
					repeat ($urandom_range(5)) begin
						if ($urandom_range(3) == 0) begin
							q.push_back("\\");
							case ($urandom_range(5))
								0: q.push_back("n");
								1: q.push_back("r");
								2: q.push_back("t");
								3: q.push_back("\"");
								4: q.push_back("\\");
								default: q.push_back(8'($urandom_range(126, 32)));
							endcase
						end else q.push_back(8'($urandom_range(255, 1)));
					end
					if ($urandom_range(7) != 0) q.push_back("\"");
				end
				6, 7: begin
					if ($urandom_range(1)) q.push_back("-");
					repeat ($urandom_range(21, 1)) q.push_back(8'($urandom_range(57, 48)));
				end
				8: begin
					q.push_back("-");
					if ($urandom_range(1)) q.push_back(8'($urandom_range(255)));
				end
				default: q.push_back(8'($urandom_range(47, 33)));
			endcase
		end
		if ($urandom_range(5) == 0) q.push_back(8'h00);
		if ($urandom_range(3) == 0) repeat ($urandom_range(3, 1)) q.push_back(8'($urandom_range(255)));
		return q;
	endfunction

	task automatic settle();
		while (pending_bytes.size() > 0 || in_valid || expected_recs.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int goal;
		byte_q_t dq;
		clear_state();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed lines
		queue_line(text("  SET k -9223372036854775808"));
		queue_line(text("push \"a\\n\\q\\\"\\"));
		queue_line(text("setx 18446744073709551617 z"));
		queue_line(text("get -x"));
		dq = text("zhas");
		dq.push_back(8'h00);
		dq.push_back("a");
		dq.push_back("b");
		queue_line(dq);
		queue_line(text({8'hff, 8'h80}));
		queue_line(text("SET \"a\"5 b"));
		settle();
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = (p == 1 || p == 3) ? 62 : 0;
			recv_stall_pct = (p == 2 || p == 3) ? 62 : 0;
			if (p == 3) begin
				send_idle_pct = 16;
				recv_stall_pct = 16;
			end
			goal = bytes_taken + pending_bytes.size() + 36;
			while (bytes_taken + pending_bytes.size() < goal)
				queue_line(random_line());
			if (p == 0) hold_cycles = 300;
			settle();
		end
		$display("lines %0d, bytes %0d, records checked %0d", lines_sent, bytes_taken,
			recs_checked);
		$display("covered four idle/stall phases and one long output hold");
		if (errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire

### filelist.f
+incdir+rtl/core
rtl/core/clt_pkg.sv
rtl/core/command_line_tokenizer.sv
rtl/core/command_line_tokenizer_checker.sv
dv/tb_command_line_tokenizer.sv
